// ===== rtl/cie_pkg.sv =====
// Package: shared types, constants and byte-class helpers for the C identifier extractor.
`default_nettype none

package cie_pkg;

    localparam int LINE_BITS     = 16;
    localparam int OUT_LINE_BITS = 16;

    localparam logic [LINE_BITS-1:0]     LINE_ONE     = LINE_BITS'(1);
    localparam logic [LINE_BITS-1:0]     LINE_MAX     = {LINE_BITS{1'b1}};
    localparam logic [OUT_LINE_BITS-1:0] OUT_LINE_MAX = {OUT_LINE_BITS{1'b1}};

    localparam logic [7:0] CH_UNDER     = 8'h5F;  // '_'
    localparam logic [7:0] CH_SLASH     = 8'h2F;  // '/'
    localparam logic [7:0] CH_STAR      = 8'h2A;  // '*'
    localparam logic [7:0] CH_SQUOTE    = 8'h27;  // single quote
    localparam logic [7:0] CH_BACKSLASH = 8'h5C;  // backslash
    localparam logic [7:0] CH_DQUOTE    = 8'h22;  // double quote
    localparam logic [7:0] CH_NEWLINE   = 8'h0A;
    localparam logic [7:0] CH_DOT       = 8'h2E;

    typedef enum logic [12:0] {
        MODE_PLAIN      = 13'b0_0000_0000_0001,
        MODE_IDENT      = 13'b0_0000_0000_0010,
        MODE_IDENT_BS   = 13'b0_0000_0000_0100,
        MODE_NUMBER     = 13'b0_0000_0000_1000,
        MODE_SLASH      = 13'b0_0000_0001_0000,
        MODE_LINE_CMT   = 13'b0_0000_0010_0000,
        MODE_LINE_BS    = 13'b0_0000_0100_0000,
        MODE_BLOCK      = 13'b0_0000_1000_0000,
        MODE_BLOCK_STAR = 13'b0_0001_0000_0000,
        MODE_STRING     = 13'b0_0010_0000_0000,
        MODE_STRING_BS  = 13'b0_0100_0000_0000,
        MODE_CHAR       = 13'b0_1000_0000_0000,
        MODE_CHAR_BS    = 13'b1_0000_0000_0000
    } lex_mode_t;

    typedef struct packed {
        lex_mode_t            mode;
        logic [7:0]           held_byte;
        logic                 held_valid;
        logic [LINE_BITS-1:0] current_line;
        logic [LINE_BITS-1:0] start_line;
    } lex_state_t;

    typedef struct packed {
        logic                     valid;
        logic [7:0]               ident_byte;
        logic                     ident_last;
        logic [OUT_LINE_BITS-1:0] line_number;
    } lex_emit_t;

    localparam lex_state_t LEX_RESET = '{
        mode:         MODE_PLAIN,
        held_byte:    8'h00,
        held_valid:   1'b0,
        current_line: LINE_ONE,
        start_line:   LINE_ONE
    };

    function automatic logic is_letter(input logic [7:0] b);
        return (b >= 8'h61 && b <= 8'h7A) || (b >= 8'h41 && b <= 8'h5A) || b == CH_UNDER;
    endfunction

    function automatic logic is_digit(input logic [7:0] b);
        return b >= 8'h30 && b <= 8'h39;
    endfunction

    // Clamp an internal line count to the output field width.
    function automatic logic [OUT_LINE_BITS-1:0] out_line(input logic [LINE_BITS-1:0] l);
        logic [LINE_BITS+OUT_LINE_BITS-1:0] ext;
        ext = (LINE_BITS + OUT_LINE_BITS)'(l);
        if (ext > (LINE_BITS + OUT_LINE_BITS)'(OUT_LINE_MAX))
            return OUT_LINE_MAX;
        return ext[OUT_LINE_BITS-1:0];
    endfunction

endpackage

`default_nettype wire

// ===== rtl/cie_text_if.sv =====
// Interfaces: source text channel and identifier byte channel.
`default_nettype none

interface cie_text_if;
    logic       valid;
    logic       ready;
    logic [7:0] text_byte;
    logic       end_of_text;

    modport source (output valid, output text_byte, output end_of_text, input ready);
    modport sink   (input valid, input text_byte, input end_of_text, output ready);
endinterface

interface cie_ident_if;
    logic                              valid;
    logic                              ready;
    logic [7:0]                        ident_byte;
    logic                              ident_last;
    logic [cie_pkg::OUT_LINE_BITS-1:0] line_number;

    modport source (output valid, output ident_byte, output ident_last,
                    output line_number, input ready);
    modport sink   (input valid, input ident_byte, input ident_last,
                    input line_number, output ready);
endinterface

`default_nettype wire

// ===== rtl/cie_lexer_core.sv =====
// Lexer core: next-state and emit decision for one text byte.
`default_nettype none

module cie_lexer_core (
    input  wire cie_pkg::lex_state_t st,
    input  wire logic [7:0]          text_byte,
    input  wire logic                end_of_text,
    output cie_pkg::lex_state_t      nxt,
    output cie_pkg::lex_emit_t       emit
);

    logic is_let;
    logic is_dig;
    logic is_nl;
    logic do_plain;
    logic bump;

    assign is_let = cie_pkg::is_letter(text_byte);
    assign is_dig = cie_pkg::is_digit(text_byte);
    assign is_nl  = (text_byte == cie_pkg::CH_NEWLINE);

    always_comb
    begin
        nxt              = st;
        emit.valid       = 1'b0;
        emit.ident_byte  = st.held_byte;
        emit.ident_last  = 1'b0;
        emit.line_number = cie_pkg::out_line(st.start_line);
        do_plain         = 1'b0;
        bump             = 1'b0;

        if (end_of_text)
        begin
            // flush the held byte as last, then back to reset state
            emit.valid      = st.held_valid;
            emit.ident_last = 1'b1;
            nxt             = cie_pkg::LEX_RESET;
        end
        else
        begin
            case (st.mode)
                cie_pkg::MODE_IDENT:
                begin
                    if (is_let || is_dig)
                    begin
                        emit.valid     = 1'b1;
                        nxt.held_byte  = text_byte;
                        nxt.held_valid = 1'b1;
                    end
                    else if (text_byte == cie_pkg::CH_BACKSLASH)
                        nxt.mode = cie_pkg::MODE_IDENT_BS;
                    else
                    begin
                        emit.valid      = 1'b1;
                        emit.ident_last = 1'b1;
                        nxt.held_valid  = 1'b0;
                        do_plain        = 1'b1;
                    end
                end
                cie_pkg::MODE_IDENT_BS:
                begin
                    if (is_nl)
                    begin
                        bump     = 1'b1;
                        nxt.mode = cie_pkg::MODE_IDENT;
                    end
                    else
                    begin
                        emit.valid      = 1'b1;
                        emit.ident_last = 1'b1;
                        nxt.held_valid  = 1'b0;
                        do_plain        = 1'b1;
                    end
                end
                cie_pkg::MODE_NUMBER:
                begin
                    if (!(is_let || is_dig || text_byte == cie_pkg::CH_DOT))
                        do_plain = 1'b1;
                end
                cie_pkg::MODE_SLASH:
                begin
                    if (text_byte == cie_pkg::CH_STAR)
                        nxt.mode = cie_pkg::MODE_BLOCK;
                    else if (text_byte == cie_pkg::CH_SLASH)
                        nxt.mode = cie_pkg::MODE_LINE_CMT;
                    else
                        do_plain = 1'b1;
                end
                cie_pkg::MODE_LINE_CMT:
                begin
                    if (is_nl)
                    begin
                        bump     = 1'b1;
                        nxt.mode = cie_pkg::MODE_PLAIN;
                    end
                    else if (text_byte == cie_pkg::CH_BACKSLASH)
                        nxt.mode = cie_pkg::MODE_LINE_BS;
                end
                cie_pkg::MODE_LINE_BS:
                begin
                    if (is_nl)
                    begin
                        bump     = 1'b1;
                        nxt.mode = cie_pkg::MODE_LINE_CMT;
                    end
                    else if (text_byte != cie_pkg::CH_BACKSLASH)
                        nxt.mode = cie_pkg::MODE_LINE_CMT;
                end
                cie_pkg::MODE_BLOCK:
                begin
                    if (is_nl)
                        bump = 1'b1;
                    else if (text_byte == cie_pkg::CH_STAR)
                        nxt.mode = cie_pkg::MODE_BLOCK_STAR;
                end
                cie_pkg::MODE_BLOCK_STAR:
                begin
                    if (text_byte == cie_pkg::CH_SLASH)
                        nxt.mode = cie_pkg::MODE_PLAIN;
                    else if (text_byte != cie_pkg::CH_STAR)
                    begin
                        bump     = is_nl;
                        nxt.mode = cie_pkg::MODE_BLOCK;
                    end
                end
                cie_pkg::MODE_STRING:
                begin
                    if (text_byte == cie_pkg::CH_DQUOTE)
                        nxt.mode = cie_pkg::MODE_PLAIN;
                    else if (text_byte == cie_pkg::CH_BACKSLASH)
                        nxt.mode = cie_pkg::MODE_STRING_BS;
                    else
                        bump = is_nl;
                end
                cie_pkg::MODE_CHAR:
                begin
                    if (text_byte == cie_pkg::CH_SQUOTE)
                        nxt.mode = cie_pkg::MODE_PLAIN;
                    else if (text_byte == cie_pkg::CH_BACKSLASH)
                        nxt.mode = cie_pkg::MODE_CHAR_BS;
                    else
                        bump = is_nl;
                end
                cie_pkg::MODE_STRING_BS:
                begin
                    bump     = is_nl;
                    nxt.mode = cie_pkg::MODE_STRING;
                end
                cie_pkg::MODE_CHAR_BS:
                begin
                    bump     = is_nl;
                    nxt.mode = cie_pkg::MODE_CHAR;
                end
                default:
                    do_plain = 1'b1;
            endcase

            // byte handled as plain code
            if (do_plain)
            begin
                if (is_let)
                begin
                    nxt.held_byte  = text_byte;
                    nxt.held_valid = 1'b1;
                    nxt.start_line = st.current_line;
                    nxt.mode       = cie_pkg::MODE_IDENT;
                end
                else if (is_dig)
                    nxt.mode = cie_pkg::MODE_NUMBER;
                else if (text_byte == cie_pkg::CH_SLASH)
                    nxt.mode = cie_pkg::MODE_SLASH;
                else if (text_byte == cie_pkg::CH_DQUOTE)
                    nxt.mode = cie_pkg::MODE_STRING;
                else if (text_byte == cie_pkg::CH_SQUOTE)
                    nxt.mode = cie_pkg::MODE_CHAR;
                else
                begin
                    bump     = is_nl;
                    nxt.mode = cie_pkg::MODE_PLAIN;
                end
            end

            // saturating line count
            if (bump && st.current_line != cie_pkg::LINE_MAX)
                nxt.current_line = st.current_line + cie_pkg::LINE_ONE;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/c_identifier_extractor_top.sv =====
// Top level of the C identifier extractor: state registers, output register, handshakes.
//
// Usage:
//   text  : sink channel, one source byte (text_byte) per transaction. A transaction
//           with end_of_text high closes the text; its text_byte is ignored, any held
//           identifier byte is flushed flagged last, and line count and lexer mode
//           return to their reset values.
//   ident : source channel, one identifier character per transaction, with
//           ident_last on the final character and line_number = line (from 1,
//           saturating at 65535) where the identifier began.
// Throughput: one text transaction per cycle unless ident stalls. The lexer state
// updates in the cycle of acceptance; the decision is one short combinational pass.
// Output: a result is registered and shows on ident in the cycle after the text
// transaction that releases it. Each identifier byte is held until a later byte
// shows whether it ends the identifier, so each byte of an identifier appears on
// ident only with a later text transaction than its own.
// Stall: text.ready is high while the output register is empty or being taken
// in the same cycle; while ident is stalled with a result waiting, text stalls.
// Reset: rst_n (async, active low) clears lexer mode to plain code, drops the
// held byte, sets the line counters to 1 and empties the output register.
`default_nettype none

module c_identifier_extractor_top (
    input  wire logic  clk,
    input  wire logic  rst_n,
    cie_text_if.sink   text,
    cie_ident_if.source ident
);

    cie_pkg::lex_state_t state_reg;
    cie_pkg::lex_state_t state_next;
    cie_pkg::lex_emit_t  emit;

    logic                              out_valid_reg;
    logic                              out_valid_next;
    logic [7:0]                        out_byte_reg;
    logic                              out_last_reg;
    logic [cie_pkg::OUT_LINE_BITS-1:0] out_line_reg;

    logic text_accept;

    cie_lexer_core u_core (
        .st          (state_reg),
        .text_byte   (text.text_byte),
        .end_of_text (text.end_of_text),
        .nxt         (state_next),
        .emit        (emit)
    );

    // Output register frees up when empty or consumed this cycle.
    assign text.ready  = !out_valid_reg || ident.ready;
    assign text_accept = text.valid && text.ready;

    always_comb
    begin
        if (text_accept)
            out_valid_next = emit.valid;
        else if (ident.ready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= cie_pkg::LEX_RESET;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            if (text_accept)
                state_reg <= state_next;
        end
    end

    // Result payload, loaded only with a new result.
    always_ff @(posedge clk)
    begin
        if (text_accept && emit.valid)
        begin
            out_byte_reg <= emit.ident_byte;
            out_last_reg <= emit.ident_last;
            out_line_reg <= emit.line_number;
        end
    end

    assign ident.valid       = out_valid_reg;
    assign ident.ident_byte  = out_byte_reg;
    assign ident.ident_last  = out_last_reg;
    assign ident.line_number = out_line_reg;

    // A held byte exists only while inside an identifier.
    a_held_in_ident: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg.held_valid |->
            (state_reg.mode == cie_pkg::MODE_IDENT || state_reg.mode == cie_pkg::MODE_IDENT_BS))
        else $error("held byte outside identifier mode");

    // End of text leaves the lexer in its reset state.
    a_eot_reset: assert property (@(posedge clk) disable iff (!rst_n)
        (text_accept && text.end_of_text) |=>
            (state_reg.mode == cie_pkg::MODE_PLAIN && !state_reg.held_valid
             && state_reg.current_line == cie_pkg::LINE_ONE))
        else $error("end of text did not restore reset state");

    // Line count never goes backward within a text.
    a_line_monotonic: assert property (@(posedge clk) disable iff (!rst_n)
        (text_accept && !text.end_of_text) |=>
            (state_reg.current_line >= $past(state_reg.current_line)))
        else $error("line count decreased");

    // Input stalls only behind a waiting result.
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        !text.ready |-> (ident.valid && !ident.ready))
        else $error("text stalled without a pending result");

endmodule

`default_nettype wire
